// ===== rtl/mcod_pkg.sv =====
package mcod_pkg;

	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 16;
	localparam int LIMIT_W  = 8;
	localparam int FAIL_W   = 8;
	localparam int CHAN_W   = 4;
	localparam int MASK_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Input command codes (carried on s_axis_tuser).
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEED_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT   = 2'd2;

	localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 16'd10;
	localparam logic [PERIOD_W-1:0] FEED_TIMEOUT_RST = 16'd10;
	localparam logic [LIMIT_W-1:0]  FAIL_LIMIT_RST   = 8'd1;
	localparam logic [FAIL_W-1:0]   FAIL_MAX         = 8'hFF;

	typedef struct packed {
		logic               tick;      // tick transfer being processed
		logic [TIME_W-1:0]  now_cur;   // counter before this item
		logic [TIME_W-1:0]  now_tick;  // counter after a tick
	} lane_ctl_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] check_period;
		logic [PERIOD_W-1:0] feed_timeout;
		logic [LIMIT_W-1:0]  fail_limit;
	} cfg_regs_t;

endpackage

// ===== rtl/mcod_lane.sv =====
module mcod_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               feed,
	input  mcod_pkg::lane_ctl_t ctl,
	input  mcod_pkg::cfg_regs_t cfg,
	output logic               online_d
);
	import mcod_pkg::*;

	logic [TIME_W-1:0] last_feed_q;
	logic [TIME_W-1:0] last_check_q;
	logic [FAIL_W-1:0] fails_q;
	logic              online_q;

	logic [TIME_W-1:0] check_age;
	logic [TIME_W-1:0] feed_age;
	logic              due;
	logic              stale;
	logic [FAIL_W-1:0] fails_next;
	logic              online_next;
	logic              check;

	assign check_age = ctl.now_tick - last_check_q;
	assign feed_age  = ctl.now_tick - last_feed_q;
	assign due       = check_age >= TIME_W'(cfg.check_period);
	assign stale     = feed_age > TIME_W'(cfg.feed_timeout);

	always_comb begin
		if (!stale) begin
			fails_next = '0;
		end else if (fails_q == FAIL_MAX) begin
			fails_next = fails_q;
		end else begin
			fails_next = fails_q + FAIL_W'(1);
		end
	end

	assign online_next = fails_next <= cfg.fail_limit;
	assign check       = ctl.tick && due;
	// The flag keeps its last verdict between checks.
	assign online_d    = check ? online_next : online_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_feed_q  <= '0;
			last_check_q <= '0;
			fails_q      <= '0;
			online_q     <= 1'b1;
		end else if (step) begin
			if (feed) begin
				last_feed_q <= ctl.now_cur;
			end
			if (check) begin
				last_check_q <= ctl.now_tick;
				fails_q      <= fails_next;
				online_q     <= online_next;
			end
		end
	end

endmodule

// ===== rtl/multi_channel_offline_detector.sv =====
// Heartbeat watchdog for up to CHANNELS devices.
// Input stream: s_axis_tuser is the command (feed or one-millisecond tick),
// s_axis_tdata[3:0] names the channel fed. A feed stamps the current time
// into that channel; a tick advances the 32-bit time counter and checks
// every channel in parallel against the shared period and timeout.
// Output stream: one transfer per input transfer, carrying the online mask
// after that item (bit i for channel i; bits at or above CHANNELS are 0).
// Configuration: cfg_we with cfg_index 0 check_period, 1 feed_timeout,
// 2 fail_limit; writes must be made only while no item is in flight.
// An input transfer is first held in the input register; the per-channel
// subtract and compare then feed the mask register, which drives the output.
// One item is accepted every cycle while the output is taken. When the
// receiver stalls, the mask register holds and one more item waits in the
// input register; after that s_axis_tready drops.
// Reset clears the counter, all timestamps and fail counts, marks every
// channel online and loads the register defaults 10, 10 and 1.
module multi_channel_offline_detector #(
	parameter int CHANNELS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [3:0] channel, [7:4] zero
	input  logic                                s_axis_tuser,  // [0] cmd
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mcod_pkg::MASK_W-1:0]         m_axis_tdata,  // [15:0] online_mask
	input  logic                                cfg_we,
	input  logic [mcod_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcod_pkg::CFG_W-1:0]          cfg_data
);
	import mcod_pkg::*;

	logic              valid_s1;
	logic              cmd_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic              out_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic [TIME_W-1:0] time_q;
	cfg_regs_t         cfg_q;

	logic              advance;
	lane_ctl_t         ctl;
	logic [CHANNELS-1:0] online_d;
	logic [MASK_W-1:0] mask_d;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = mask_q;

	assign ctl.tick     = (cmd_s1 == CMD_TICK);
	assign ctl.now_cur  = time_q;
	assign ctl.now_tick = time_q + TIME_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_period <= CHECK_PERIOD_RST;
			cfg_q.feed_timeout <= FEED_TIMEOUT_RST;
			cfg_q.fail_limit   <= FAIL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHECK_PERIOD: cfg_q.check_period <= cfg_data;
				REG_FEED_TIMEOUT: cfg_q.feed_timeout <= cfg_data;
				REG_FAIL_LIMIT:   cfg_q.fail_limit   <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			chan_s1 <= s_axis_tdata[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (advance && ctl.tick) begin
			time_q <= ctl.now_tick;
		end
	end

	genvar i;
	generate
		for (i = 0; i < CHANNELS; i++) begin : g_lane
			logic feed_hit;
			if (i < (1 << CHAN_W)) begin : g_addr
				assign feed_hit = (cmd_s1 == CMD_FEED) && (chan_s1 == CHAN_W'(i));
			end else begin : g_noaddr
				assign feed_hit = 1'b0;
			end
			mcod_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.step     (advance),
				.feed     (feed_hit),
				.ctl      (ctl),
				.cfg      (cfg_q),
				.online_d (online_d[i])
			);
		end
		for (i = 0; i < MASK_W; i++) begin : g_mask
			if (i < CHANNELS) begin : g_on
				assign mask_d[i] = online_d[i];
			end else begin : g_off
				assign mask_d[i] = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q <= mask_d;
		end
	end

endmodule
